>>> design/lccc_pkg.sv
package lccc_pkg;

    localparam int ROW_W       = 6;
    localparam int VALUE_W     = 32;
    localparam int ACT_W       = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int OUT_TDATA_W = 48;
    localparam int PAD_W       = OUT_TDATA_W - 2 * ROW_W - VALUE_W;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 2'd1;

    localparam logic [ACT_W-1:0] ACTIVE_RESET = 7'd64;
    localparam int               WEIGHT_RESET = 656;

    // output queue: holds finished entries until the downstream side takes them
    localparam int QDEPTH = 8;
    localparam int QPTR_W = 3;
    localparam int QCNT_W = 4;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [ROW_W-1:0]   col;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               fend;
    } t_result;

endpackage

>>> design/lccc_ram.sv
module lccc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/leaky_cross_channel_correlation.sv
// a sample of channel l runs l+1 read-modify-write operations on the single port pair of
//   the correlation memory after its accept, then a 3-stage drain; reads stall while no
//   queue space can be reserved, and a new sample is taken only once the last has drained
// results queue in an 8-entry output buffer
// reset: synchronous active low; registers go to 64 channels and weight 656, position 0;
//   correlation rows not yet visited read as zero via a row fill mark, no clearing pass
module leaky_cross_channel_correlation #(
    parameter int CHANNELS    = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // [SAMPLE_BITS-1:0] sample, zero fill above
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [5:0] row, [11:6] column, [43:12] value, zero fill above
    output logic [lccc_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    output logic                                 o_m_tlast,
    // [0] frame_end
    output logic                                 o_m_tuser,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lccc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [WEIGHT_BITS-1:0]               i_cfg_data
);

    localparam int CH_W        = $clog2(CHANNELS);
    localparam int CNT_W       = $clog2(CHANNELS + 1);
    localparam int STORE_DEPTH = CHANNELS * (CHANNELS + 1) / 2;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PROD_W      = 2 * SAMPLE_BITS;
    localparam int VW          = lccc_pkg::VALUE_W;

    lccc_pkg::t_state r_state;
    lccc_pkg::t_state n_state;

    logic [lccc_pkg::ACT_W-1:0] r_active;
    logic [WEIGHT_BITS-1:0]     r_weight;
    logic [CH_W-1:0]            r_pos;
    logic [CNT_W-1:0]           r_rows_seen;

    logic [CH_W-1:0]        r_row;
    logic [SAMPLE_BITS-1:0] r_x;
    logic [ADDR_W-1:0]      r_base;
    logic                   r_fend;
    logic                   r_fresh;
    logic [CH_W-1:0]        r_k;

    logic              r_v1, r_v2, r_v3;
    logic [CH_W-1:0]   r_col1, r_col2, r_col3;
    logic [ADDR_W-1:0] r_addr1, r_addr2, r_addr3;
    logic [VW-1:0]     r_p2, r_m2, r_keep3, r_add3;

    lccc_pkg::t_result         r_queue [lccc_pkg::QDEPTH];
    logic [lccc_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [lccc_pkg::QCNT_W-1:0] r_qcount, r_used;

    logic [CNT_W-1:0]       w_count;
    logic [CH_W-1:0]        w_l;
    logic                   w_fend;
    logic [2*CNT_W-1:0]     w_tri;
    logic [ADDR_W-1:0]      w_base;
    logic                   w_accept;
    logic                   w_issue;
    logic                   w_pop;
    logic                   w_push;
    logic [ADDR_W-1:0]      w_raddr;
    logic [SAMPLE_BITS-1:0] w_samp_rd;
    logic [VW-1:0]          w_store_rd;
    logic [SAMPLE_BITS-1:0] w_xk;
    logic [PROD_W-1:0]      w_prod;
    logic [VW-1:0]          w_p32;
    logic [VW-1:0]          w_m;
    logic [WEIGHT_BITS:0]   w_omw;
    logic [VW+WEIGHT_BITS:0]   w_keep_full;
    logic [VW+WEIGHT_BITS-1:0] w_add_full;
    logic [VW:0]            w_sum;
    logic [VW-1:0]          w_value;
    lccc_pkg::t_result      w_entry;
    lccc_pkg::t_result      w_head;

    // effective channel count: zero acts as one, large values clamp
    always_comb begin
        priority if (r_active == '0) begin
            w_count = CNT_W'(1);
        end else if (r_active > lccc_pkg::ACT_W'(CHANNELS)) begin
            w_count = CNT_W'(CHANNELS);
        end else begin
            w_count = CNT_W'(r_active);
        end
    end

    assign w_l    = (CNT_W'(r_pos) >= w_count) ? '0 : r_pos;
    assign w_fend = (CNT_W'(w_l) + CNT_W'(1)) == w_count;
    assign w_tri  = (2*CNT_W)'(w_l) * ((2*CNT_W)'(w_l) + (2*CNT_W)'(1));
    assign w_base = ADDR_W'(w_tri >> 1);

    assign w_accept = i_s_tvalid & o_s_tready;
    assign w_pop    = o_m_tvalid & i_m_tready;
    assign w_push   = r_v3;
    assign w_raddr  = r_base + ADDR_W'(r_k);
    assign o_cfg_ready = 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lccc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = lccc_pkg::ST_RUN;
                end
            end
            lccc_pkg::ST_RUN: begin
                if (w_issue && r_k == '0) begin
                    n_state = lccc_pkg::ST_IDLE;
                end
            end
            default: n_state = lccc_pkg::ST_IDLE;
        endcase
    end

    // state outputs: one read issued per cycle while queue space is reserved
    always_comb begin
        w_issue    = 1'b0;
        o_s_tready = 1'b0;
        unique case (r_state)
            lccc_pkg::ST_IDLE: begin
                o_s_tready = !r_v1 && !r_v2 && !r_v3;
            end
            lccc_pkg::ST_RUN: begin
                w_issue = r_used < lccc_pkg::QCNT_W'(lccc_pkg::QDEPTH);
            end
            default: begin
                w_issue    = 1'b0;
                o_s_tready = 1'b0;
            end
        endcase
    end

    lccc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (CHANNELS)
    ) u_samples (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (w_l),
        .i_wdata (i_s_tdata[SAMPLE_BITS-1:0]),
        .i_re    (w_issue),
        .i_raddr (r_k),
        .o_rdata (w_samp_rd)
    );

    lccc_ram #(
        .WIDTH (VW),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_addr3),
        .i_wdata (w_value),
        .i_re    (w_issue),
        .i_raddr (w_raddr),
        .o_rdata (w_store_rd)
    );

    // stage 1: own sample bypasses the memory, fresh rows read as zero
    assign w_xk   = (r_col1 == r_row) ? r_x : w_samp_rd;
    assign w_prod = {{SAMPLE_BITS{1'b0}}, r_x} * {{SAMPLE_BITS{1'b0}}, w_xk};
    assign w_m    = r_fresh ? '0 : w_store_rd;

    generate
        if (PROD_W >= VW) begin : g_prod_trunc
            assign w_p32 = w_prod[PROD_W-1 -: VW];
        end else begin : g_prod_ext
            assign w_p32 = {w_prod, {(VW-PROD_W){1'b0}}};
        end
    endgenerate

    // stage 2: leak old entry, weight new product
    assign w_omw       = {1'b1, {WEIGHT_BITS{1'b0}}} - {1'b0, r_weight};
    assign w_keep_full = (VW+WEIGHT_BITS+1)'(r_m2) * (VW+WEIGHT_BITS+1)'(w_omw);
    assign w_add_full  = (VW+WEIGHT_BITS)'(r_p2) * (VW+WEIGHT_BITS)'(r_weight);

    // stage 3: sum, write back and queue
    assign w_sum   = {1'b0, r_keep3} + {1'b0, r_add3};
    assign w_value = w_sum[VW] ? '1 : w_sum[VW-1:0];

    always_comb begin
        w_entry.row   = lccc_pkg::ROW_W'(r_row);
        w_entry.col   = lccc_pkg::ROW_W'(r_col3);
        w_entry.value = w_value;
        w_entry.last  = (r_col3 == '0);
        w_entry.fend  = r_fend;
    end

    assign w_head     = r_queue[r_rd];
    assign o_m_tvalid = (r_qcount != '0);
    assign o_m_tdata  = {{lccc_pkg::PAD_W{1'b0}}, w_head.value, w_head.col, w_head.row};
    assign o_m_tlast  = w_head.last;
    assign o_m_tuser  = w_head.fend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lccc_pkg::ST_IDLE;
            r_active    <= lccc_pkg::ACTIVE_RESET;
            r_weight    <= WEIGHT_BITS'(lccc_pkg::WEIGHT_RESET);
            r_pos       <= '0;
            r_rows_seen <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_wr        <= '0;
            r_rd        <= '0;
            r_qcount    <= '0;
            r_used      <= '0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;

            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == lccc_pkg::REG_ACTIVE) begin
                    r_active <= i_cfg_data[lccc_pkg::ACT_W-1:0];
                end else if (i_cfg_index == lccc_pkg::REG_WEIGHT) begin
                    r_weight <= i_cfg_data;
                end
            end

            if (w_accept) begin
                r_pos <= w_fend ? '0 : w_l + CH_W'(1);
                if (CNT_W'(w_l) == r_rows_seen) begin
                    r_rows_seen <= r_rows_seen + CNT_W'(1);
                end
            end

            if (w_push) begin
                r_wr <= r_wr + lccc_pkg::QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + lccc_pkg::QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_qcount <= r_qcount + lccc_pkg::QCNT_W'(1);
            end else if (!w_push && w_pop) begin
                r_qcount <= r_qcount - lccc_pkg::QCNT_W'(1);
            end
            if (w_issue && !w_pop) begin
                r_used <= r_used + lccc_pkg::QCNT_W'(1);
            end else if (!w_issue && w_pop) begin
                r_used <= r_used - lccc_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_row   <= w_l;
            r_x     <= i_s_tdata[SAMPLE_BITS-1:0];
            r_base  <= w_base;
            r_fend  <= w_fend;
            r_fresh <= (CNT_W'(w_l) == r_rows_seen);
            r_k     <= w_l;
        end else if (w_issue && r_k != '0) begin
            r_k <= r_k - CH_W'(1);
        end

        r_col1  <= r_k;
        r_addr1 <= w_raddr;

        r_col2  <= r_col1;
        r_addr2 <= r_addr1;
        r_p2    <= w_p32;
        r_m2    <= w_m;

        r_col3  <= r_col2;
        r_addr3 <= r_addr2;
        r_keep3 <= w_keep_full[WEIGHT_BITS +: VW];
        r_add3  <= w_add_full[WEIGHT_BITS +: VW];

        if (w_push) begin
            r_queue[r_wr] <= w_entry;
        end
    end

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= lccc_pkg::QCNT_W'(lccc_pkg::QDEPTH) && r_qcount <= r_used)
        else $error("queue reservation out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (r_qcount < lccc_pkg::QCNT_W'(lccc_pkg::QDEPTH) || w_pop))
        else $error("result pushed into a full queue");

    a_write_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (r_addr3 >= r_base && r_addr3 <= r_base + ADDR_W'(r_row)))
        else $error("write back outside the current row");

    a_last_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && r_col3 == '0) |-> (r_state == lccc_pkg::ST_IDLE && !r_v1 && !r_v2))
        else $error("work in flight behind the last entry");

endmodule
